### rtl/core/utf8_text_page_breaker_defines.svh
// Assertion macros shared by the page breaker RTL.
// No dependencies; included by the files that carry assertions.
`ifndef UTF8_TEXT_PAGE_BREAKER_DEFINES_SVH
`define UTF8_TEXT_PAGE_BREAKER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication
`define UPB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8pb: assertion failed");
// Next-cycle implication
`define UPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8pb: assertion failed");
`else
`define UPB_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define UPB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/utf8pb_pkg.sv
// Types, constants and helpers for the UTF-8 page breaker.
// No dependencies; imported by every module of the block.
package utf8pb_pkg;

    // Coordinate and arithmetic widths
    localparam int COORD_BITS = 12;
    localparam int SUM_W      = ((COORD_BITS > 12) ? COORD_BITS : 12) + 2;
    localparam int POS_W      = 32;
    localparam int CODE_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    typedef logic [COORD_BITS-1:0] t_coord;
    localparam t_coord COORD_MAX = '1;

    // Command codes on the input channel
    typedef enum logic [1:0] {
        FUNC_BEGIN = 2'd0,
        FUNC_BYTE  = 2'd1,
        FUNC_END   = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 3'd0,
        CFG_SCREEN_HEIGHT = 3'd1,
        CFG_MARGIN_LR     = 3'd2,
        CFG_MARGIN_TOP    = 3'd3,
        CFG_BOTTOM_PAD    = 3'd4,
        CFG_NARROW_WIDTH  = 3'd5,
        CFG_WIDE_WIDTH    = 3'd6,
        CFG_LINE_GAP      = 3'd7
    } t_cfg_idx;

    // End reasons
    localparam logic REASON_FULL = 1'b0;
    localparam logic REASON_END  = 1'b1;

    // Character codes
    localparam logic [CODE_W-1:0] CHAR_QMARK   = 16'h003F;
    localparam logic [CODE_W-1:0] CHAR_LF      = 16'h000A;
    localparam logic [CODE_W-1:0] CHAR_CR      = 16'h000D;
    localparam logic [CODE_W-1:0] NARROW_LIMIT = 16'd128;

    // UTF-8 byte classes
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD2_BITS = 8'h1F;
    localparam logic [7:0] LEAD3_BITS = 8'h0F;
    localparam logic [7:0] CONT_BITS  = 8'h3F;

    typedef struct packed {
        logic [11:0] screen_width;
        logic [11:0] screen_height;
        logic [10:0] margin_lr;
        logic [10:0] margin_top;
        logic [10:0] bottom_pad;
        logic [7:0]  narrow_width;
        logic [7:0]  wide_width;
        logic [7:0]  line_gap;
    } t_cfg;

    // Layout position carried between characters
    typedef struct packed {
        t_coord           x;
        t_coord           y;
        logic             indent;
        logic [POS_W-1:0] pos;
    } t_lay_state;

    typedef struct packed {
        t_lay_state nxt;
        logic       done;
        logic       reason;
    } t_lay_res;

    // Clamp a widened sum to the coordinate range
    function automatic t_coord coord_sat(input logic [SUM_W-1:0] v);
        if (v > {{(SUM_W-COORD_BITS){1'b0}}, COORD_MAX}) begin
            return COORD_MAX;
        end
        return v[COORD_BITS-1:0];
    endfunction

endpackage

### rtl/core/utf8pb_cfg_regs.sv
// Configuration register file of the page breaker.
// Depends on utf8pb_pkg.
module utf8pb_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [utf8pb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [utf8pb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output utf8pb_pkg::t_cfg                    o_cfg
);
    import utf8pb_pkg::*;

    t_cfg r_cfg;

    // Register writes keep only each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width  <= 12'd540;
            r_cfg.screen_height <= 12'd960;
            r_cfg.margin_lr     <= 11'd56;
            r_cfg.margin_top    <= 11'd105;
            r_cfg.bottom_pad    <= 11'd114;
            r_cfg.narrow_width  <= 8'd14;
            r_cfg.wide_width    <= 8'd24;
            r_cfg.line_gap      <= 8'd14;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data[11:0];
                CFG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data[11:0];
                CFG_MARGIN_LR:     r_cfg.margin_lr     <= i_cfg_data[10:0];
                CFG_MARGIN_TOP:    r_cfg.margin_top    <= i_cfg_data[10:0];
                CFG_BOTTOM_PAD:    r_cfg.bottom_pad    <= i_cfg_data[10:0];
                CFG_NARROW_WIDTH:  r_cfg.narrow_width  <= i_cfg_data[7:0];
                CFG_WIDE_WIDTH:    r_cfg.wide_width    <= i_cfg_data[7:0];
                CFG_LINE_GAP:      r_cfg.line_gap      <= i_cfg_data[7:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/utf8pb_layout.sv
// Places one decoded character: indent, wrap, line feed, page-full and zero-code checks.
// Depends on utf8pb_pkg; purely combinational.
module utf8pb_layout (
    input  utf8pb_pkg::t_cfg                    i_cfg,
    input  logic [utf8pb_pkg::CODE_W-1:0]       i_code,
    input  logic [1:0]                          i_len,
    input  utf8pb_pkg::t_lay_state              i_st,
    output utf8pb_pkg::t_lay_res                o_res
);
    import utf8pb_pkg::*;

    logic [7:0]       adv;
    logic [SUM_W-1:0] y_step;
    t_coord           y_down;
    t_coord           x_marg;
    t_coord           x_ind;
    t_coord           x0;
    t_coord           x1;
    t_coord           y1;
    t_coord           x2;
    logic             wrap;
    logic             full;
    logic [POS_W-1:0] pos_inc;

    // Advance and line step
    assign adv    = (i_code < NARROW_LIMIT) ? i_cfg.narrow_width : i_cfg.wide_width;
    assign y_step = SUM_W'(i_st.y) + SUM_W'(i_cfg.wide_width) + SUM_W'(i_cfg.line_gap);
    assign y_down = coord_sat(y_step);
    assign x_marg = coord_sat(SUM_W'(i_cfg.margin_lr));
    assign x_ind  = coord_sat(SUM_W'(i_cfg.margin_lr) + SUM_W'({i_cfg.wide_width, 1'b0}));

    // Pending indent, then right-margin wrap (x + adv > width - margin)
    assign x0   = i_st.indent ? x_ind : i_st.x;
    assign wrap = (SUM_W'(x0) + SUM_W'(adv) + SUM_W'(i_cfg.margin_lr))
                  > SUM_W'(i_cfg.screen_width);
    assign x1   = wrap ? x_marg : x0;
    assign y1   = wrap ? y_down : i_st.y;

    // Bottom check (y + glyph height > height - pad)
    assign full = (SUM_W'(y1) + SUM_W'(i_cfg.wide_width) + SUM_W'(i_cfg.bottom_pad))
                  > SUM_W'(i_cfg.screen_height);

    // Carriage return takes no advance
    assign x2      = (i_code == CHAR_CR) ? x1 : coord_sat(SUM_W'(x1) + SUM_W'(adv));
    assign pos_inc = i_st.pos + POS_W'(i_len);

    always_comb begin
        o_res.nxt    = i_st;
        o_res.done   = 1'b0;
        o_res.reason = REASON_FULL;
        if (i_code == '0) begin
            // zero code ends the page before this sequence
            o_res.done   = 1'b1;
            o_res.reason = REASON_END;
        end else if (i_code == CHAR_LF) begin
            o_res.nxt.x      = x_marg;
            o_res.nxt.y      = y_down;
            o_res.nxt.indent = 1'b1;
            o_res.nxt.pos    = pos_inc;
        end else if (full) begin
            // character does not fit: offset stays before it
            o_res.nxt.x      = x1;
            o_res.nxt.y      = y1;
            o_res.nxt.indent = 1'b0;
            o_res.done       = 1'b1;
            o_res.reason     = REASON_FULL;
        end else begin
            o_res.nxt.x      = x2;
            o_res.nxt.y      = y1;
            o_res.nxt.indent = 1'b0;
            o_res.nxt.pos    = pos_inc;
        end
    end

endmodule

### rtl/core/utf8pb_engine.sv
// Input stage, UTF-8 decoder state, layout state and output register.
// Depends on utf8pb_pkg, utf8pb_layout and the assertion macro header.
`include "utf8_text_page_breaker_defines.svh"
module utf8pb_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  utf8pb_pkg::t_cfg                    i_cfg,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_func,
    input  logic [7:0]                          i_data_byte,
    input  logic [utf8pb_pkg::POS_W-1:0]        i_start_offset,
    input  logic                                i_starts_paragraph,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [utf8pb_pkg::POS_W-1:0]        o_page_end_offset,
    output logic                                o_end_reason
);
    import utf8pb_pkg::*;

    // Input stage
    logic             r_stg_vld;
    t_func            r_stg_func;
    logic [7:0]       r_stg_byte;
    logic [POS_W-1:0] r_stg_offset;
    logic             r_stg_para;

    // Decoder and page state
    logic [1:0]        r_seq_need, n_seq_need;
    logic [1:0]        r_seq_total, n_seq_total;
    logic [CODE_W-1:0] r_partial, n_partial;
    t_lay_state        r_lay, n_lay;
    logic              r_active, n_active;

    // Output register
    logic             r_out_vld;
    logic [POS_W-1:0] r_out_off;
    logic             r_out_reason;

    logic              out_free;
    logic              exec;
    logic              replay;
    logic              stg_take;
    logic              in_acc;
    logic              is_cont;
    logic              is_lead2;
    logic              is_lead3;
    logic [CODE_W-1:0] partial_cat;
    logic              lay_go;
    logic [CODE_W-1:0] lay_code;
    logic [1:0]        lay_len;
    logic              bad_cont;
    t_lay_res          lay_res;
    logic              out_fire;
    logic [POS_W-1:0]  out_off;
    logic              out_reason;

    // Handshake: the stage runs whenever the output slot can take a beat
    assign out_free   = !r_out_vld || i_out_ready;
    assign exec       = r_stg_vld && out_free;
    assign stg_take   = exec && !replay;
    assign o_in_ready = !r_stg_vld || stg_take;
    assign in_acc     = i_in_valid && o_in_ready;

    // Byte classes
    assign is_cont     = (r_stg_byte & CONT_MASK) == CONT_TAG;
    assign is_lead2    = (r_stg_byte & LEAD2_MASK) == LEAD2_TAG;
    assign is_lead3    = (r_stg_byte & LEAD3_MASK) == LEAD3_TAG;
    assign partial_cat = {r_partial[CODE_W-7:0], r_stg_byte[5:0]};

    // Which character, if any, goes to the layout unit this cycle
    always_comb begin
        lay_go   = 1'b0;
        lay_code = CHAR_QMARK;
        lay_len  = 2'd1;
        bad_cont = 1'b0;
        if (exec && r_active && r_stg_func == FUNC_BYTE) begin
            if (r_seq_need != 2'd0) begin
                if (is_cont) begin
                    if (r_seq_need == 2'd1) begin
                        lay_go   = 1'b1;
                        lay_code = partial_cat;
                        lay_len  = r_seq_total;
                    end
                end else begin
                    // broken sequence: '?' covers the bytes taken so far
                    lay_go   = 1'b1;
                    lay_len  = r_seq_total - r_seq_need;
                    bad_cont = 1'b1;
                end
            end else if (r_stg_byte == 8'h00) begin
                lay_go = 1'b1;
            end else if (r_stg_byte < CONT_TAG) begin
                lay_go   = 1'b1;
                lay_code = CODE_W'(r_stg_byte);
            end else if (!is_lead2 && !is_lead3) begin
                lay_go = 1'b1;
            end
        end
    end

    utf8pb_layout u_layout (
        .i_cfg  (i_cfg),
        .i_code (lay_code),
        .i_len  (lay_len),
        .i_st   (r_lay),
        .o_res  (lay_res)
    );

    // Next state
    always_comb begin
        n_seq_need  = r_seq_need;
        n_seq_total = r_seq_total;
        n_partial   = r_partial;
        n_lay       = r_lay;
        n_active    = r_active;
        replay      = 1'b0;
        out_fire    = 1'b0;
        out_off     = r_lay.pos;
        out_reason  = REASON_END;
        if (exec) begin
            unique case (r_stg_func)
                FUNC_BEGIN: begin
                    n_lay.pos    = r_stg_offset;
                    n_lay.indent = r_stg_para;
                    n_lay.x      = coord_sat(SUM_W'(i_cfg.margin_lr));
                    n_lay.y      = coord_sat(SUM_W'(i_cfg.margin_top));
                    n_seq_need   = 2'd0;
                    n_seq_total  = 2'd0;
                    n_partial    = '0;
                    n_active     = 1'b1;
                end
                FUNC_END: begin
                    if (r_active) begin
                        out_fire    = 1'b1;
                        n_active    = 1'b0;
                        n_seq_need  = 2'd0;
                        n_seq_total = 2'd0;
                    end
                end
                FUNC_BYTE: begin
                    if (r_active) begin
                        if (r_seq_need != 2'd0) begin
                            if (is_cont) begin
                                n_partial  = partial_cat;
                                n_seq_need = r_seq_need - 2'd1;
                                if (r_seq_need == 2'd1) begin
                                    n_seq_total = 2'd0;
                                end
                            end else begin
                                n_seq_need  = 2'd0;
                                n_seq_total = 2'd0;
                            end
                        end else if (is_lead2) begin
                            n_partial   = CODE_W'(r_stg_byte & LEAD2_BITS);
                            n_seq_need  = 2'd1;
                            n_seq_total = 2'd2;
                        end else if (is_lead3) begin
                            n_partial   = CODE_W'(r_stg_byte & LEAD3_BITS);
                            n_seq_need  = 2'd2;
                            n_seq_total = 2'd3;
                        end
                    end
                end
                FUNC_NONE: begin
                end
            endcase

            if (lay_go) begin
                n_lay = lay_res.nxt;
                if (lay_res.done) begin
                    out_fire    = 1'b1;
                    out_reason  = lay_res.reason;
                    n_active    = 1'b0;
                    n_seq_need  = 2'd0;
                    n_seq_total = 2'd0;
                end else if (bad_cont) begin
                    // keep the byte staged and decode it again as the start of a new character
                    replay = 1'b1;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
            r_active    <= 1'b0;
            r_seq_need  <= 2'd0;
            r_seq_total <= 2'd0;
            r_partial   <= '0;
            r_lay       <= '0;
        end else begin
            if (in_acc) begin
                r_stg_vld <= 1'b1;
            end else if (stg_take) begin
                r_stg_vld <= 1'b0;
            end
            if (out_fire) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            r_active    <= n_active;
            r_seq_need  <= n_seq_need;
            r_seq_total <= n_seq_total;
            r_partial   <= n_partial;
            r_lay       <= n_lay;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_stg_func   <= t_func'(i_func);
            r_stg_byte   <= i_data_byte;
            r_stg_offset <= i_start_offset;
            r_stg_para   <= i_starts_paragraph;
        end
        if (out_fire) begin
            r_out_off    <= out_off;
            r_out_reason <= out_reason;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_page_end_offset = r_out_off;
    assign o_end_reason      = r_out_reason;

    // Checks on decoder and page state
    `UPB_ASSERT_NOW(a_seq_len, i_clk, i_rst_n, r_seq_need != 2'd0, r_seq_total > r_seq_need)
    `UPB_ASSERT_NOW(a_idle_no_seq, i_clk, i_rst_n, !r_active, r_seq_need == 2'd0)
    `UPB_ASSERT_NEXT(a_replay, i_clk, i_rst_n, replay, r_stg_vld && r_active && r_seq_need == 2'd0)
    `UPB_ASSERT_NOW(a_fire_active, i_clk, i_rst_n, out_fire, r_active && exec)

endmodule

### rtl/core/utf8_text_page_breaker.sv
// Top level of the UTF-8 page breaker: config registers and processing engine.
// Depends on utf8pb_pkg, utf8pb_cfg_regs and utf8pb_engine.
//
// Usage: send a begin beat (func 0) with the page's start offset and paragraph
// flag, then one beat per text byte (func 1), then an end-of-text beat (func 2).
// The block returns one result beat per page: the offset where the next page
// begins and the reason (page full, or end of text / zero code). Bytes and end
// marks seen outside a page produce no result.
// Input and output use valid/ready. A beat is captured in the input stage register
// and processed from there into the output register. One beat per cycle is taken
// while the receiver does not stall; a byte that breaks a multi-byte sequence
// is held in the input stage and processed again: the '?' for the broken
// sequence is placed first and the byte is then decoded as a new start byte.
// If the receiver stalls, one finished result waits in the output register and
// one more beat waits in the input stage; after that ready drops.
// Reset (synchronous, active low) loads the default geometry, empties both
// registers and leaves the block idle until a begin beat. Configuration
// writes take effect at once and are meant for idle periods.
module utf8_text_page_breaker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [utf8pb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [utf8pb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_func,
    input  logic [7:0]                          i_data_byte,
    input  logic [utf8pb_pkg::POS_W-1:0]        i_start_offset,
    input  logic                                i_starts_paragraph,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [utf8pb_pkg::POS_W-1:0]        o_page_end_offset,
    output logic                                o_end_reason
);
    import utf8pb_pkg::*;

    t_cfg cfg;

    utf8pb_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    utf8pb_engine u_engine (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_func             (i_func),
        .i_data_byte        (i_data_byte),
        .i_start_offset     (i_start_offset),
        .i_starts_paragraph (i_starts_paragraph),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_page_end_offset  (o_page_end_offset),
        .o_end_reason       (o_end_reason)
    );

endmodule
